// ===== rtl/altu_pkg.sv =====
// Shared constants, operation codes and controller/datapath command types.
package altu_pkg;

	localparam int Capacity  = 256;
	localparam int ElemWidth = 32;
	localparam int IdxWidth  = $clog2(Capacity);
	localparam int CntWidth  = IdxWidth + 1;

	localparam logic [3:0] OP_APPEND    = 4'd0;
	localparam logic [3:0] OP_INSERT    = 4'd1;
	localparam logic [3:0] OP_REMOVE_AT = 4'd2;
	localparam logic [3:0] OP_REMOVE_V  = 4'd3;
	localparam logic [3:0] OP_FIND_FST  = 4'd4;
	localparam logic [3:0] OP_FIND_LST  = 4'd5;
	localparam logic [3:0] OP_BSEARCH   = 4'd6;
	localparam logic [3:0] OP_READ      = 4'd7;
	localparam logic [3:0] OP_WRITE     = 4'd8;
	localparam logic [3:0] OP_CLEAR     = 4'd9;
	localparam logic [3:0] OP_REVERSE   = 4'd10;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Datapath commands from the controller.
	typedef struct packed {
		logic                 mem_rd;
		logic [IdxWidth-1:0]  rd_addr;
		logic                 mem_wr;
		logic [IdxWidth-1:0]  wr_addr;
		logic                 wr_sel_val;  // write the item value, else held data
		logic                 hold_ld;     // capture read data into hold register
		logic                 rdata_ld;    // capture read data as result read data
	} dp_cmd_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic                 eq;
		logic                 gt;
	} dp_sts_t;

endpackage

// ===== rtl/altu_datapath.sv =====
// Element memory, hold register and compare logic of the list store.
module altu_datapath
	import altu_pkg::*;
(
	input  logic                 clk,
	input  dp_cmd_t              cmd,
	input  logic [ElemWidth-1:0] value_q,
	output dp_sts_t              sts,
	output logic [ElemWidth-1:0] rd_result
);

	logic [ElemWidth-1:0] mem_q [Capacity];
	logic [ElemWidth-1:0] rd_q;
	logic [ElemWidth-1:0] hold_q;
	logic [ElemWidth-1:0] res_q;

	// Write one entry and read one entry per cycle.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_q[cmd.wr_addr] <= cmd.wr_sel_val ? value_q : hold_q;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[cmd.rd_addr];
		end
	end

	// Capture read data for shifts and swaps and for the read result.
	always_ff @(posedge clk) begin
		if (cmd.hold_ld) begin
			hold_q <= rd_q;
		end
		if (cmd.rdata_ld) begin
			res_q <= rd_q;
		end
	end

	assign sts.eq    = (rd_q == value_q);
	assign sts.gt    = (rd_q > value_q);
	assign rd_result = res_q;

endmodule

// ===== rtl/altu_ctrl.sv =====
// Controller state machine sequencing list operations over the datapath.
module altu_ctrl
	import altu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          op,
	input  logic [IdxWidth-1:0] position,
	input  dp_sts_t             sts,
	output dp_cmd_t             cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [IdxWidth-1:0] found_index,
	output logic                rdata_vld,
	output logic [CntWidth-1:0] length,
	output logic [1:0]          status
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_INS_RD = 4'd2;
	localparam logic [3:0] S_INS_WR = 4'd3;
	localparam logic [3:0] S_DN_RD  = 4'd4;
	localparam logic [3:0] S_DN_WR  = 4'd5;
	localparam logic [3:0] S_SRCH   = 4'd6;
	localparam logic [3:0] S_SCHK   = 4'd7;
	localparam logic [3:0] S_BS     = 4'd8;
	localparam logic [3:0] S_BCHK   = 4'd9;
	localparam logic [3:0] S_RD     = 4'd10;
	localparam logic [3:0] S_RV_A   = 4'd11;
	localparam logic [3:0] S_RV_B   = 4'd12;
	localparam logic [3:0] S_RV_W   = 4'd13;
	localparam logic [3:0] S_RV_W2  = 4'd14;
	localparam logic [3:0] S_DONE   = 4'd15;

	logic [3:0]          state_q;
	logic [3:0]          op_q;
	logic [IdxWidth-1:0] pos_q;
	logic [CntWidth-1:0] cnt_q;
	logic [CntWidth-1:0] i_q;      // walking index
	logic [CntWidth-1:0] j_q;      // second index for reverse
	logic [CntWidth:0]   lo_q;
	logic [CntWidth:0]   hi_q;
	logic                found_q;
	logic [IdxWidth-1:0] fidx_q;
	logic [1:0]          status_q;
	logic                rdv_q;
	logic                res_vld_q;
	logic [CntWidth:0]   mid;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Issue memory commands for the current state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_INS_RD: begin
				cmd.mem_rd  = (i_q != {1'b0, pos_q});
				cmd.rd_addr = i_q[IdxWidth-1:0] - 1'b1;
				cmd.mem_wr  = (i_q != cnt_q);
				cmd.wr_addr = i_q[IdxWidth-1:0] + 1'b1;
			end
			S_INS_WR: begin
				if (i_q == {1'b0, pos_q}) begin
					cmd.mem_wr     = 1'b1;
					cmd.wr_addr    = pos_q;
					cmd.wr_sel_val = 1'b1;
				end else begin
					cmd.hold_ld = 1'b1;
				end
			end
			S_DN_RD: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_addr = i_q[IdxWidth-1:0] + 1'b1;
			end
			S_DN_WR: begin
				cmd.hold_ld = 1'b1;
			end
			S_SRCH: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_addr = i_q[IdxWidth-1:0];
			end
			S_BS: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_addr = mid[IdxWidth-1:0];
			end
			S_RD: begin
				cmd.rdata_ld = 1'b1;
			end
			S_RV_A: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_addr = i_q[IdxWidth-1:0];
			end
			S_RV_B: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_addr = j_q[IdxWidth-1:0];
				cmd.hold_ld = 1'b1;
			end
			S_RV_W: begin
				cmd.mem_wr  = 1'b1;
				cmd.wr_addr = j_q[IdxWidth-1:0];
				cmd.hold_ld = 1'b1;
			end
			S_RV_W2: begin
				cmd.mem_wr  = 1'b1;
				cmd.wr_addr = i_q[IdxWidth-1:0];
			end
			S_DISP: begin
				cmd.mem_rd  = (op_q == OP_READ);
				cmd.rd_addr = pos_q;
				cmd.mem_wr  = (op_q == OP_APPEND && cnt_q < CntWidth'(Capacity))
					|| (op_q == OP_WRITE && {1'b0, pos_q} < cnt_q);
				cmd.wr_addr = (op_q == OP_APPEND) ? cnt_q[IdxWidth-1:0] : pos_q;
				cmd.wr_sel_val = 1'b1;
			end
			default: begin
			end
		endcase
		// Shift writes come out of the hold register in the cycle after capture.
		if (state_q == S_DN_RD && i_q != {1'b0, pos_q}) begin
			cmd.mem_wr  = 1'b1;
			cmd.wr_addr = i_q[IdxWidth-1:0] - 1'b1;
		end
	end

	// Sequence each operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			res_vld_q <= 1'b0;
			op_q      <= '0;
			pos_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			found_q   <= 1'b0;
			fidx_q    <= '0;
			status_q  <= ST_OK;
			rdv_q     <= 1'b0;
		end else begin
			if (res_vld_q && out_ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !res_vld_q) begin
						op_q     <= op;
						pos_q    <= position;
						found_q  <= 1'b0;
						fidx_q   <= '0;
						status_q <= ST_OK;
						rdv_q    <= 1'b0;
						state_q  <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_DONE;
					unique case (op_q)
						OP_APPEND: begin
							if (cnt_q >= CntWidth'(Capacity)) status_q <= ST_FULL;
							else cnt_q <= cnt_q + 1'b1;
						end
						OP_INSERT: begin
							if ({1'b0, pos_q} > cnt_q) status_q <= ST_RANGE;
							else if (cnt_q >= CntWidth'(Capacity)) status_q <= ST_FULL;
							else begin
								i_q     <= cnt_q;
								state_q <= S_INS_RD;
							end
						end
						OP_REMOVE_AT: begin
							if ({1'b0, pos_q} >= cnt_q) status_q <= ST_RANGE;
							else begin
								i_q     <= {1'b0, pos_q};
								state_q <= S_DN_RD;
							end
						end
						OP_REMOVE_V: begin
							if (cnt_q != '0) begin
								i_q     <= '0;
								state_q <= S_SRCH;
							end
						end
						OP_FIND_FST, OP_FIND_LST: begin
							if ({1'b0, pos_q} >= cnt_q) status_q <= ST_RANGE;
							else begin
								i_q     <= {1'b0, pos_q};
								state_q <= S_SRCH;
							end
						end
						OP_BSEARCH: begin
							if (cnt_q != '0) begin
								lo_q    <= '0;
								hi_q    <= {1'b0, cnt_q} - 1'b1;
								state_q <= S_BS;
							end
						end
						OP_READ, OP_WRITE: begin
							if ({1'b0, pos_q} >= cnt_q) status_q <= ST_RANGE;
							else if (op_q == OP_READ) state_q <= S_RD;
						end
						OP_CLEAR: cnt_q <= '0;
						OP_REVERSE: begin
							if (cnt_q > CntWidth'(1)) begin
								i_q     <= '0;
								j_q     <= cnt_q - 1'b1;
								state_q <= S_RV_A;
							end
						end
						default: begin
						end
					endcase
				end
				// Insert: read i-1 while the held element goes to i+1; value lands at pos last.
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					if (i_q == {1'b0, pos_q}) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_INS_RD;
					end
				end
				// Remove: read i+1, write it at i (write happens next read).
				S_DN_RD: begin
					if (i_q + 1'b1 >= cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_DN_RD;
				end
				S_SRCH: state_q <= S_SCHK;
				S_SCHK: begin
					if (sts.eq) begin
						found_q <= 1'b1;
						fidx_q  <= i_q[IdxWidth-1:0];
						if (op_q == OP_REMOVE_V) begin
							pos_q   <= i_q[IdxWidth-1:0];
							state_q <= S_DN_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (op_q == OP_FIND_LST) begin
						if (i_q == '0) state_q <= S_DONE;
						else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_SRCH;
						end
					end else begin
						if (i_q + 1'b1 >= cnt_q) state_q <= S_DONE;
						else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SRCH;
						end
					end
				end
				S_BS: begin
					i_q     <= mid[CntWidth-1:0];
					state_q <= S_BCHK;
				end
				S_BCHK: begin
					if (sts.eq) begin
						found_q <= 1'b1;
						fidx_q  <= i_q[IdxWidth-1:0];
						state_q <= S_DONE;
					end else if (sts.gt) begin
						if (i_q == '0 || {1'b0, i_q} - 1'b1 < lo_q) state_q <= S_DONE;
						else begin
							hi_q    <= {1'b0, i_q} - 1'b1;
							state_q <= S_BS;
						end
					end else begin
						if ({1'b0, i_q} + 1'b1 > hi_q) state_q <= S_DONE;
						else begin
							lo_q    <= {1'b0, i_q} + 1'b1;
							state_q <= S_BS;
						end
					end
				end
				S_RD: begin
					rdv_q   <= 1'b1;
					state_q <= S_DONE;
				end
				// Reverse: read both ends, then swap them.
				S_RV_A:  state_q <= S_RV_B;
				S_RV_B:  state_q <= S_RV_W;
				S_RV_W:  state_q <= S_RV_W2;
				S_RV_W2: begin
					if (i_q + 1'b1 >= j_q - 1'b1) state_q <= S_DONE;
					else begin
						i_q     <= i_q + 1'b1;
						j_q     <= j_q - 1'b1;
						state_q <= S_RV_A;
					end
				end
				S_DONE: begin
					if (!res_vld_q || out_ready) begin
						res_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE) && !res_vld_q;
	assign out_valid   = res_vld_q;
	assign found       = found_q;
	assign found_index = fidx_q;
	assign rdata_vld   = rdv_q;
	assign length      = cnt_q;
	assign status      = status_q;

endmodule

// ===== rtl/array_list_table_engine_unit.sv =====
// Top level of the list store: controller, datapath and result register.
// Insert and remove shift the moved elements one at a time, searches probe one element
// at a time, and reverse swaps one pair of elements at a time.
// Throughput: one item at a time; next item accepted the cycle after the result transfers.
// Reset clears the count and control; the element memory is not cleared.
module array_list_table_engine_unit
	import altu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           op,
	input  logic [7:0]           position,
	input  logic [31:0]          value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic [7:0]           found_index,
	output logic [31:0]          read_data,
	output logic [8:0]           length,
	output logic [1:0]           status
);

	dp_cmd_t              cmd;
	dp_sts_t              sts;
	logic [ElemWidth-1:0] value_q;
	logic [ElemWidth-1:0] rd_result;
	logic                 rdata_vld;
	logic                 in_ready_c;

	// Hold the item value for the whole operation.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready_c) begin
			value_q <= value;
		end
	end

	altu_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready(in_ready_c), .op, .position,
		.sts, .cmd, .out_valid, .out_ready, .found, .found_index,
		.rdata_vld, .length, .status
	);

	altu_datapath u_dp (
		.clk, .cmd, .value_q, .sts, .rd_result
	);

	assign in_ready  = in_ready_c;
	assign read_data = rdata_vld ? rd_result : '0;

endmodule

// ===== rtl/altu_checker.sv =====
// Port-level checker for the list store, bound to the top level.
module altu_checker
	import altu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        found,
	input  logic [7:0]  found_index,
	input  logic [8:0]  length,
	input  logic [1:0]  status
);

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		length <= 9'(Capacity)) else $error("length beyond capacity");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status code");

	a_nf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_index == 8'd0) else $error("index without find");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(length))
		else $error("result dropped");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("second transfer while busy");

endmodule

bind array_list_table_engine_unit altu_checker u_altu_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.found, .found_index, .length, .status
);
